[sv/vsog_pkg.sv]
`timescale 1ns / 1ps

package vsog_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned VEL_W     = 16;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned HEAD_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MASK_W    = 2 * AXES;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_DIST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_TIME  = 3'd3;

  // reset values
  localparam logic signed [15:0] FWD_THR_RST   = 16'sd205;
  localparam logic        [31:0] RST_DIST_SQ   = 32'd2500;
  localparam logic signed [15:0] RST_ANGLE_RST = 16'sd819;
  localparam logic signed [31:0] RST_TIME_RST  = -32'sd1;

  // per-axis sign of the last executed command
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  localparam logic CMD_EXEC  = 1'b0;
  localparam logic CMD_SCORE = 1'b1;

endpackage

[sv/vsog_if.sv]
`timescale 1ns / 1ps

interface vsog_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      command;
  logic signed [vsog_pkg::VEL_W-1:0]         vel_x;
  logic signed [vsog_pkg::VEL_W-1:0]         vel_y;
  logic signed [vsog_pkg::VEL_W-1:0]         vel_theta;
  logic signed [vsog_pkg::POS_W-1:0]         pos_x;
  logic signed [vsog_pkg::POS_W-1:0]         pos_y;
  logic signed [vsog_pkg::HEAD_W-1:0]        heading;
  logic        [vsog_pkg::TIME_W-1:0]        timestamp;

  modport source (
    output valid, command, vel_x, vel_y, vel_theta, pos_x, pos_y, heading, timestamp,
    input  ready
  );
  modport sink (
    input  valid, command, vel_x, vel_y, vel_theta, pos_x, pos_y, heading, timestamp,
    output ready
  );
endinterface

interface vsog_out_if;
  logic                          valid;
  logic                          ready;
  logic                          oscillating;
  logic                          new_restriction;
  logic                          restrictions_cleared;
  logic [vsog_pkg::MASK_W-1:0]   restriction_mask;

  modport source (
    output valid, oscillating, new_restriction, restrictions_cleared, restriction_mask,
    input  ready
  );
  modport sink (
    input  valid, oscillating, new_restriction, restrictions_cleared, restriction_mask,
    output ready
  );
endinterface

[sv/velocity_sign_oscillation_guard_unit.sv]
`timescale 1ns / 1ps

// channel   | dir | beat payload
// ----------+-----+-----------------------------------------------------------
// in_item   | in  | command, vel_x/y/theta, pos_x, pos_y, heading, timestamp
// out_res   | out | oscillating, new_restriction, restrictions_cleared, mask
// cfg_*     | in  | write enable, register index, 32 bit data
//
// One beat per clock while out_res is not stalled; a beat taken on in_item goes
// through the input register, then the result register, to out_res.
// The trend, anchor and clear update is done combinationally between the
// two registers, so each beat sees the state left by the one before it.
// rst_n (synchronous) clears trends, anchor and both valid flags and loads
// the register defaults. A stall on out_res holds the input register full;
// in_item is refused only while both stages hold a beat.

module velocity_sign_oscillation_guard_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  vsog_in_if.sink                             in_item,
  vsog_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [vsog_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [vsog_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  localparam int unsigned DX_W = vsog_pkg::POS_W + 1;
  localparam int unsigned SQ_W = 2 * DX_W;
  localparam int unsigned DA_W = vsog_pkg::HEAD_W + 2;

  // configuration
  logic signed [15:0] fwd_thr_r;
  logic               rd_neg_r;
  logic        [31:0] rd_sq_r;
  logic signed [15:0] rst_angle_r;
  logic signed [31:0] rst_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_thr_r   <= vsog_pkg::FWD_THR_RST;
      rd_neg_r    <= 1'b0;
      rd_sq_r     <= vsog_pkg::RST_DIST_SQ;
      rst_angle_r <= vsog_pkg::RST_ANGLE_RST;
      rst_time_r  <= vsog_pkg::RST_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        vsog_pkg::CFG_FWD_THR:   fwd_thr_r   <= cfg_wdata[15:0];
        vsog_pkg::CFG_RST_DIST: begin
          rd_neg_r <= cfg_wdata[16];
          rd_sq_r  <= 32'(cfg_wdata[15:0]) * 32'(cfg_wdata[15:0]);
        end
        vsog_pkg::CFG_RST_ANGLE: rst_angle_r <= cfg_wdata[15:0];
        vsog_pkg::CFG_RST_TIME:  rst_time_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic                                  s1_valid_r;
  logic                                  s1_cmd_r;
  logic signed [vsog_pkg::VEL_W-1:0]     s1_vel_r [vsog_pkg::AXES];
  logic signed [vsog_pkg::POS_W-1:0]     s1_px_r;
  logic signed [vsog_pkg::POS_W-1:0]     s1_py_r;
  logic signed [vsog_pkg::HEAD_W-1:0]    s1_hd_r;
  logic        [vsog_pkg::TIME_W-1:0]    s1_ts_r;

  logic out_valid_r;
  logic s1_adv_w;
  logic in_ready_w;

  assign s1_adv_w   = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_ready_w = !s1_valid_r || s1_adv_w;
  assign in_item.ready = in_ready_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready_w) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready_w && in_item.valid) begin
      s1_cmd_r    <= in_item.command;
      s1_vel_r[0] <= in_item.vel_x;
      s1_vel_r[1] <= in_item.vel_y;
      s1_vel_r[2] <= in_item.vel_theta;
      s1_px_r     <= in_item.pos_x;
      s1_py_r     <= in_item.pos_y;
      s1_hd_r     <= in_item.heading;
      s1_ts_r     <= in_item.timestamp;
    end
  end

  // trend state and anchor
  logic [1:0]                         last_sign_r   [vsog_pkg::AXES];
  logic [1:0]                         last_sign_nxt [vsog_pkg::AXES];
  logic [vsog_pkg::AXES-1:0]          pos_only_r, pos_only_nxt;
  logic [vsog_pkg::AXES-1:0]          neg_only_r, neg_only_nxt;
  logic signed [vsog_pkg::POS_W-1:0]  anchor_x_r, anchor_y_r;
  logic signed [vsog_pkg::HEAD_W-1:0] anchor_hd_r;
  logic        [vsog_pkg::TIME_W-1:0] anchor_ts_r;

  // forward speed gate for side and turn tracking
  logic signed [16:0] abs_vx_w;
  logic               track_w;

  assign abs_vx_w = s1_vel_r[0][15] ? -17'(s1_vel_r[0]) : 17'(s1_vel_r[0]);
  assign track_w  = fwd_thr_r[15] || (abs_vx_w <= 17'(fwd_thr_r));

  // reset tests against the stored anchor
  logic signed [DX_W-1:0] dx_w, dy_w;
  logic signed [SQ_W-1:0] dx_sq_w, dy_sq_w;
  logic        [SQ_W:0]   d2_w;
  logic signed [DA_W-1:0] dh_w, abs_dh_w;
  logic        [31:0]     elapsed_w;
  logic                   dist_hit_w, angle_hit_w, time_hit_w, clear_due_w;

  assign dx_w      = DX_W'(s1_px_r) - DX_W'(anchor_x_r);
  assign dy_w      = DX_W'(s1_py_r) - DX_W'(anchor_y_r);
  assign dx_sq_w   = dx_w * dx_w;
  assign dy_sq_w   = dy_w * dy_w;
  assign d2_w      = (SQ_W+1)'(unsigned'(dx_sq_w)) + (SQ_W+1)'(unsigned'(dy_sq_w));
  assign dist_hit_w = !rd_neg_r && (d2_w > (SQ_W+1)'(rd_sq_r));

  assign dh_w       = DA_W'(s1_hd_r) - DA_W'(anchor_hd_r);
  assign abs_dh_w   = dh_w[DA_W-1] ? -dh_w : dh_w;
  assign angle_hit_w = !rst_angle_r[15] && (abs_dh_w > DA_W'(rst_angle_r));

  assign elapsed_w  = s1_ts_r - anchor_ts_r;
  assign time_hit_w = !rst_time_r[31] && (elapsed_w > unsigned'(rst_time_r));

  assign clear_due_w = dist_hit_w || angle_hit_w || time_hit_w;

  logic                      set_w, clr_w, osc_w;
  logic [vsog_pkg::MASK_W-1:0] mask_nxt, mask_cur;

  always_comb begin
    set_w         = 1'b0;
    clr_w         = 1'b0;
    osc_w         = 1'b0;
    last_sign_nxt = last_sign_r;
    pos_only_nxt  = pos_only_r;
    neg_only_nxt  = neg_only_r;
    mask_cur      = '0;
    for (int a = 0; a < vsog_pkg::AXES; a++) begin
      mask_cur[2*a]   = pos_only_r[a];
      mask_cur[2*a+1] = neg_only_r[a];
      if ((pos_only_r[a] && s1_vel_r[a][15]) ||
          (neg_only_r[a] && !s1_vel_r[a][15] && (s1_vel_r[a] != '0))) begin
        osc_w = 1'b1;
      end
      if ((a == 0) || track_w) begin
        if (s1_vel_r[a][15]) begin
          if (last_sign_r[a] == vsog_pkg::SIGN_POS) begin
            neg_only_nxt[a] = 1'b1;
            set_w           = 1'b1;
          end
          last_sign_nxt[a] = vsog_pkg::SIGN_NEG;
        end else if (s1_vel_r[a] != '0) begin
          if (last_sign_r[a] == vsog_pkg::SIGN_NEG) begin
            pos_only_nxt[a] = 1'b1;
            set_w           = 1'b1;
          end
          last_sign_nxt[a] = vsog_pkg::SIGN_POS;
        end
      end
    end
    // a fresh anchor sits at the current pose, so no test can pass then
    if (!set_w && ((|pos_only_nxt) || (|neg_only_nxt)) && clear_due_w) begin
      clr_w = 1'b1;
      for (int a = 0; a < vsog_pkg::AXES; a++) begin
        last_sign_nxt[a] = vsog_pkg::SIGN_ZERO;
      end
      pos_only_nxt = '0;
      neg_only_nxt = '0;
    end
    mask_nxt = '0;
    for (int a = 0; a < vsog_pkg::AXES; a++) begin
      mask_nxt[2*a]   = pos_only_nxt[a];
      mask_nxt[2*a+1] = neg_only_nxt[a];
    end
  end

  logic exec_w;
  assign exec_w = s1_adv_w && (s1_cmd_r == vsog_pkg::CMD_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < vsog_pkg::AXES; a++) begin
        last_sign_r[a] <= vsog_pkg::SIGN_ZERO;
      end
      pos_only_r  <= '0;
      neg_only_r  <= '0;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      anchor_hd_r <= '0;
      anchor_ts_r <= '0;
    end else if (exec_w) begin
      last_sign_r <= last_sign_nxt;
      pos_only_r  <= pos_only_nxt;
      neg_only_r  <= neg_only_nxt;
      if (set_w) begin
        anchor_x_r  <= s1_px_r;
        anchor_y_r  <= s1_py_r;
        anchor_hd_r <= s1_hd_r;
        anchor_ts_r <= s1_ts_r;
      end
    end
  end

  // result register
  logic                        out_osc_r, out_new_r, out_clr_r;
  logic [vsog_pkg::MASK_W-1:0] out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv_w) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv_w) begin
      if (s1_cmd_r == vsog_pkg::CMD_SCORE) begin
        out_osc_r  <= osc_w;
        out_new_r  <= 1'b0;
        out_clr_r  <= 1'b0;
        out_mask_r <= mask_cur;
      end else begin
        out_osc_r  <= 1'b0;
        out_new_r  <= set_w;
        out_clr_r  <= clr_w;
        out_mask_r <= mask_nxt;
      end
    end
  end

  assign out_res.valid                = out_valid_r;
  assign out_res.oscillating          = out_osc_r;
  assign out_res.new_restriction      = out_new_r;
  assign out_res.restrictions_cleared = out_clr_r;
  assign out_res.restriction_mask     = out_mask_r;

  a_clear_empties_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clr_r) |-> (out_mask_r == '0))
    else $error("cleared result carries restrictions");

  a_clear_excludes_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_clr_r && out_new_r))
    else $error("new restriction and clear in one beat");

  a_osc_needs_restriction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_osc_r) |-> (out_mask_r != '0))
    else $error("oscillation flagged with no restriction");

  a_anchor_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_w && set_w) |=> (anchor_ts_r == $past(s1_ts_r) && anchor_x_r == $past(s1_px_r)))
    else $error("anchor not stored on new restriction");

endmodule
